// ===== sv/psa_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the postfix stack alu
package psa_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  typedef enum logic [2:0] {
    MODE_PUSH     = 3'd0,
    MODE_POP      = 3'd1,
    MODE_ADD      = 3'd2,
    MODE_SUB      = 3'd3,
    MODE_MUL      = 3'd4,
    MODE_DIV      = 3'd5,
    MODE_PEEK_TOP = 3'd6,
    MODE_PEEK_BOT = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FEW   = 3'd2,
    ST_RANGE = 3'd3,
    ST_DIV0  = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_PEEK_WAIT,
    S_RD_S,
    S_EXEC,
    S_ALU,
    S_DIV_WAIT,
    S_WB
  } state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_PEEK_TOP,
    RD_PEEK_BOT
  } rd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_DEC2
  } cnt_op_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_OPND,
    VAL_RDATA,
    VAL_RES
  } val_sel_t;

  typedef struct packed {
    logic     load;
    rd_sel_t  rd_sel;
    cnt_op_t  cnt_op;
    logic     wr_en;
    logic     wr_from_res;
    logic     latch_t;
    logic     latch_s;
    logic     alu_load;
    logic     div_start;
    logic     div_load;
    logic     emit;
    val_sel_t val_sel;
    status_t  status;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  full;
    logic  few;
    logic  range_err;
    logic  t_zero;
    logic  div_done;
  } stat_t;

endpackage

// ===== sv/postfix_stack_alu.sv =====
// top level of the postfix stack alu: controller, datapath and port checks
//
// usage
// - command channel: a word (in_mode, in_operand, in_index) is taken at a
//   rising edge with start high and busy low; busy stays high until the
//   instruction has finished, so one instruction runs at a time
// - result channel: out_strobe is high for exactly one cycle with out_value,
//   out_status and out_depth; the receiver cannot stall, so it must take the
//   word in that cycle
// - divide runs on the iterative divider, one quotient bit per cycle over
//   32 bits; the stack memory has a single read port, so top and second
//   operand are read in consecutive cycles
// - synchronous reset (rst_n low) empties the stack and idles the controller;
//   stack memory contents are not cleared, only entries below the depth are
//   ever read
// - errors give value zero and leave the stack unchanged, except divide by
//   zero, which consumes both operands
module postfix_stack_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_operand,
  input  logic [7:0]         in_index,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status,
  output logic [8:0]         out_depth
);

  // command and status buses between controller and datapath
  psa_pkg::cmd_t  cmd;
  psa_pkg::stat_t stat;

  psa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  psa_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_mode),
    .in_operand (in_operand),
    .in_index   (in_index),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_status (out_status),
    .out_depth  (out_depth)
  );

  // an accepted word always raises busy in the cycle after it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  // one result per instruction, never in back-to-back cycles
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // error results carry a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != psa_pkg::ST_OK)) |-> (out_value == '0))
    else $error("nonzero value on error result");

  // reported depth never exceeds the stack size
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_depth <= 9'(psa_pkg::STACK_DEPTH)))
    else $error("depth beyond stack size");

endmodule

// ===== sv/psa_div.sv =====
// iterative unsigned restoring divider, one quotient bit per cycle
module psa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psa_pkg::DATA_W-1:0]  dividend,
  input  logic [psa_pkg::DATA_W-1:0]  divisor,
  output logic [psa_pkg::DATA_W-1:0]  quotient,
  output logic                        done
);

  logic [psa_pkg::DATA_W-1:0]    rem_r, rem_nxt;
  logic [psa_pkg::DATA_W-1:0]    quo_r, quo_nxt;
  logic [psa_pkg::DATA_W-1:0]    dvs_r;
  logic [psa_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;
  logic [psa_pkg::DATA_W:0]      shifted;
  logic [psa_pkg::DATA_W:0]      diff;

  always_comb begin
    shifted = {rem_r, quo_r[psa_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (diff[psa_pkg::DATA_W]) begin
      rem_nxt = shifted[psa_pkg::DATA_W-1:0];
    end else begin
      rem_nxt = diff[psa_pkg::DATA_W-1:0];
    end
    quo_nxt = {quo_r[psa_pkg::DATA_W-2:0], ~diff[psa_pkg::DATA_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + psa_pkg::DIV_CNT_W'(1);
        if (cnt_r == psa_pkg::DIV_CNT_W'(psa_pkg::DATA_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== sv/psa_dpath.sv =====
// datapath: stack memory, depth counter, operand registers, alu and result registers
module psa_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psa_pkg::cmd_t              cmd,
  output psa_pkg::stat_t             stat,
  input  logic [2:0]                 in_mode,
  input  logic [psa_pkg::DATA_W-1:0] in_operand,
  input  logic [7:0]                 in_index,
  output logic                       out_strobe,
  output logic [psa_pkg::DATA_W-1:0] out_value,
  output logic [2:0]                 out_status,
  output logic [psa_pkg::CNT_W-1:0]  out_depth
);

  logic [psa_pkg::DATA_W-1:0] mem [psa_pkg::STACK_DEPTH];

  psa_pkg::mode_t             mode_r;
  logic [psa_pkg::DATA_W-1:0] opnd_r;
  logic [7:0]                 idx_r;
  logic [psa_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [psa_pkg::DATA_W-1:0] rdata_r;
  logic [psa_pkg::DATA_W-1:0] t_r, s_r, res_r;
  logic                       strobe_r;
  logic [psa_pkg::DATA_W-1:0] value_r;
  logic [2:0]                 status_r;
  logic [psa_pkg::CNT_W-1:0]  depth_r;

  logic [psa_pkg::CNT_W-1:0]  rd_full;
  logic [psa_pkg::ADDR_W-1:0] rd_addr;
  logic [psa_pkg::DATA_W-1:0] wr_data;
  logic [psa_pkg::DATA_W-1:0] emit_val;
  logic [psa_pkg::DATA_W-1:0] alu_res;
  logic [psa_pkg::DATA_W-1:0] s_mag, t_mag, quo, quo_signed;
  logic                       div_done;

  // depth counter
  always_comb begin
    case (cmd.cnt_op)
      psa_pkg::CNT_INC:  count_nxt = count_r + psa_pkg::CNT_W'(1);
      psa_pkg::CNT_DEC:  count_nxt = count_r - psa_pkg::CNT_W'(1);
      psa_pkg::CNT_DEC2: count_nxt = count_r - psa_pkg::CNT_W'(2);
      default:           count_nxt = count_r;
    endcase
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      psa_pkg::RD_TOP:      rd_full = count_r - psa_pkg::CNT_W'(1);
      psa_pkg::RD_SECOND:   rd_full = count_r - psa_pkg::CNT_W'(2);
      psa_pkg::RD_PEEK_TOP: rd_full = count_r - psa_pkg::CNT_W'(1) - psa_pkg::CNT_W'(idx_r);
      default:              rd_full = psa_pkg::CNT_W'(idx_r);
    endcase
    rd_addr = rd_full[psa_pkg::ADDR_W-1:0];
    wr_data = cmd.wr_from_res ? res_r : opnd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[count_r[psa_pkg::ADDR_W-1:0]] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // add, subtract, multiply (low word)
  always_comb begin
    case (mode_r)
      psa_pkg::MODE_ADD: alu_res = s_r + t_r;
      psa_pkg::MODE_SUB: alu_res = s_r - t_r;
      default:           alu_res = s_r * t_r;
    endcase
  end

  // signed divide through magnitudes
  assign s_mag      = s_r[psa_pkg::DATA_W-1] ? (~s_r + psa_pkg::DATA_W'(1)) : s_r;
  assign t_mag      = t_r[psa_pkg::DATA_W-1] ? (~t_r + psa_pkg::DATA_W'(1)) : t_r;
  assign quo_signed = (s_r[psa_pkg::DATA_W-1] ^ t_r[psa_pkg::DATA_W-1]) ?
                      (~quo + psa_pkg::DATA_W'(1)) : quo;

  psa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (s_mag),
    .divisor  (t_mag),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    case (cmd.val_sel)
      psa_pkg::VAL_OPND:  emit_val = opnd_r;
      psa_pkg::VAL_RDATA: emit_val = rdata_r;
      psa_pkg::VAL_RES:   emit_val = res_r;
      default:            emit_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
      mode_r   <= psa_pkg::MODE_PUSH;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= cmd.emit;
      if (cmd.load) begin
        mode_r <= psa_pkg::mode_t'(in_mode);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r <= in_operand;
      idx_r  <= in_index;
    end
    if (cmd.latch_t) begin
      t_r <= rdata_r;
    end
    if (cmd.latch_s) begin
      s_r <= rdata_r;
    end
    if (cmd.alu_load) begin
      res_r <= alu_res;
    end else if (cmd.div_load) begin
      res_r <= quo_signed;
    end
    if (cmd.emit) begin
      value_r  <= emit_val;
      status_r <= cmd.status;
      depth_r  <= count_nxt;
    end
  end

  always_comb begin
    stat.mode      = mode_r;
    stat.empty     = (count_r == '0);
    stat.full      = (count_r >= psa_pkg::CNT_W'(psa_pkg::STACK_DEPTH));
    stat.few       = (count_r < psa_pkg::CNT_W'(2));
    stat.range_err = (psa_pkg::CNT_W'(idx_r) >= count_r);
    stat.t_zero    = (t_r == '0);
    stat.div_done  = div_done;
  end

  assign out_strobe = strobe_r;
  assign out_value  = value_r;
  assign out_status = status_r;
  assign out_depth  = depth_r;

endmodule

// ===== sv/psa_ctrl.sv =====
// controller state machine sequencing each stack instruction
module psa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  psa_pkg::stat_t stat,
  output psa_pkg::cmd_t  cmd
);

  psa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != psa_pkg::S_IDLE);
    case (state_r)
      psa_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = psa_pkg::S_DECODE;
        end
      end
      psa_pkg::S_DECODE: begin
        case (stat.mode)
          psa_pkg::MODE_PUSH: begin
            cmd.emit  = 1'b1;
            state_nxt = psa_pkg::S_IDLE;
            if (stat.full) begin
              cmd.status = psa_pkg::ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.cnt_op  = psa_pkg::CNT_INC;
              cmd.val_sel = psa_pkg::VAL_OPND;
            end
          end
          psa_pkg::MODE_POP: begin
            if (stat.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = psa_pkg::ST_EMPTY;
              state_nxt  = psa_pkg::S_IDLE;
            end else begin
              cmd.rd_sel = psa_pkg::RD_TOP;
              cmd.cnt_op = psa_pkg::CNT_DEC;
              state_nxt  = psa_pkg::S_POP_WAIT;
            end
          end
          psa_pkg::MODE_PEEK_TOP, psa_pkg::MODE_PEEK_BOT: begin
            if (stat.range_err) begin
              cmd.emit   = 1'b1;
              cmd.status = psa_pkg::ST_RANGE;
              state_nxt  = psa_pkg::S_IDLE;
            end else begin
              cmd.rd_sel = (stat.mode == psa_pkg::MODE_PEEK_TOP) ?
                           psa_pkg::RD_PEEK_TOP : psa_pkg::RD_PEEK_BOT;
              state_nxt  = psa_pkg::S_PEEK_WAIT;
            end
          end
          default: begin
            if (stat.few) begin
              cmd.emit   = 1'b1;
              cmd.status = psa_pkg::ST_FEW;
              state_nxt  = psa_pkg::S_IDLE;
            end else begin
              cmd.rd_sel = psa_pkg::RD_TOP;
              state_nxt  = psa_pkg::S_RD_S;
            end
          end
        endcase
      end
      psa_pkg::S_POP_WAIT, psa_pkg::S_PEEK_WAIT: begin
        cmd.emit    = 1'b1;
        cmd.val_sel = psa_pkg::VAL_RDATA;
        state_nxt   = psa_pkg::S_IDLE;
      end
      psa_pkg::S_RD_S: begin
        cmd.latch_t = 1'b1;
        cmd.rd_sel  = psa_pkg::RD_SECOND;
        state_nxt   = psa_pkg::S_EXEC;
      end
      psa_pkg::S_EXEC: begin
        cmd.latch_s = 1'b1;
        cmd.cnt_op  = psa_pkg::CNT_DEC2;
        state_nxt   = psa_pkg::S_ALU;
      end
      psa_pkg::S_ALU: begin
        if (stat.mode == psa_pkg::MODE_DIV) begin
          if (stat.t_zero) begin
            cmd.emit   = 1'b1;
            cmd.status = psa_pkg::ST_DIV0;
            state_nxt  = psa_pkg::S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = psa_pkg::S_DIV_WAIT;
          end
        end else begin
          cmd.alu_load = 1'b1;
          state_nxt    = psa_pkg::S_WB;
        end
      end
      psa_pkg::S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_nxt    = psa_pkg::S_WB;
        end
      end
      psa_pkg::S_WB: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_from_res = 1'b1;
        cmd.cnt_op      = psa_pkg::CNT_INC;
        cmd.emit        = 1'b1;
        cmd.val_sel     = psa_pkg::VAL_RES;
        state_nxt       = psa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = psa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== verif/tb_postfix_stack_alu.sv =====
// self-checking testbench for the postfix stack alu: directed corners, a full stack, random programs
module tb_postfix_stack_alu;

  // no word accepted for this many cycles means the block hung; the slowest
  // correct word is a divide behind the longest sender gap
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last result, well above the divide latency
  localparam int TAIL_CYCLES    = 50;
  localparam int WORDS_IDLING   = 1700;
  localparam int WORDS_TOTAL    = 1950;

  localparam logic [31:0] MOST_NEG  = 32'h8000_0000;
  localparam logic [31:0] MOST_POS  = 32'h7fff_ffff;
  localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

  typedef struct {
    logic [31:0]      value;
    psa_pkg::status_t status;
    logic [8:0]       depth;
  } rpn_result_t;

  // every input is known from time zero
  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  logic [2:0]         in_mode    = '0;
  logic signed [31:0] in_operand = '0;
  logic [7:0]         in_index   = '0;
  logic               out_strobe;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;
  logic [8:0]         out_depth;

  // predictor state: its own copy of the operand stack
  logic [31:0] rpn_stack [psa_pkg::STACK_DEPTH];
  int          rpn_depth = 0;

  rpn_result_t pending_results[$];
  int          errors          = 0;
  int          words_sent      = 0;
  int          results_checked = 0;
  int          status_seen [6] = '{default: 0};
  int          stall_cycles    = 0;

  // stimulus side guess of the depth, resynced from the predictor whenever
  // the pipe is drained (divide by zero makes it drift by one)
  int depth_guess  = 0;
  bit sender_idles = 1'b0;

  postfix_stack_alu DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_operand (in_operand),
    .in_index   (in_index),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_status (out_status),
    .out_depth  (out_depth)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor: runs one instruction on the local stack, returns its result
  // ---------------------------------------------------------------------
  task automatic rpn_execute(input psa_pkg::mode_t op, input logic [31:0] opnd,
                             input logic [7:0] idx, output rpn_result_t r);
    logic [31:0] top_v;
    logic [31:0] second_v;
    logic [31:0] res_v;
    logic [31:0] mag_s;
    logic [31:0] mag_t;
    r.value  = '0;
    r.status = psa_pkg::ST_OK;
    res_v    = '0;
    case (op)
      psa_pkg::MODE_PUSH: begin
        if (rpn_depth >= psa_pkg::STACK_DEPTH) begin
          r.status = psa_pkg::ST_FULL;
        end else begin
          rpn_stack[rpn_depth] = opnd;
          rpn_depth++;
          r.value = opnd;
        end
      end
      psa_pkg::MODE_POP: begin
        if (rpn_depth == 0) begin
          r.status = psa_pkg::ST_EMPTY;
        end else begin
          rpn_depth--;
          r.value = rpn_stack[rpn_depth];
        end
      end
      psa_pkg::MODE_ADD, psa_pkg::MODE_SUB, psa_pkg::MODE_MUL, psa_pkg::MODE_DIV: begin
        if (rpn_depth < 2) begin
          r.status = psa_pkg::ST_FEW;
        end else begin
          top_v     = rpn_stack[rpn_depth - 1];
          second_v  = rpn_stack[rpn_depth - 2];
          rpn_depth = rpn_depth - 2;
          case (op)
            psa_pkg::MODE_ADD: res_v = second_v + top_v;
            psa_pkg::MODE_SUB: res_v = second_v - top_v;
            psa_pkg::MODE_MUL: res_v = second_v * top_v;   // low 32 bits only
            default: begin
              // divide on magnitudes so the most negative over minus one wraps
              // instead of trapping; sign fixed up afterwards (toward zero)
              mag_s = second_v[31] ? -second_v : second_v;
              mag_t = top_v[31] ? -top_v : top_v;
              if (top_v != 0) begin
                res_v = mag_s / mag_t;
                if (second_v[31] ^ top_v[31]) begin
                  res_v = -res_v;
                end
              end
            end
          endcase
          // divide by zero leaves both operands consumed, nothing pushed
          if (op == psa_pkg::MODE_DIV && top_v == 0) begin
            r.status = psa_pkg::ST_DIV0;
          end else begin
            rpn_stack[rpn_depth] = res_v;
            rpn_depth++;
            r.value = res_v;
          end
        end
      end
      default: begin
        // both peek modes; an empty stack always lands here as out of range
        if (idx >= rpn_depth) begin
          r.status = psa_pkg::ST_RANGE;
        end else if (op == psa_pkg::MODE_PEEK_TOP) begin
          r.value = rpn_stack[rpn_depth - 1 - idx];
        end else begin
          r.value = rpn_stack[idx];
        end
      end
    endcase
    r.depth = rpn_depth[8:0];
  endtask

  // ---------------------------------------------------------------------
  // checker: results against the oldest expectation, then record new words
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rpn_result_t exp_r;
    if (rst_n) begin
      if (out_strobe) begin
        results_checked++;
        if (out_status < 6) begin
          status_seen[out_status]++;
        end
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got value %h status %0d depth %0d",
                   $time, out_value, out_status, out_depth);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_value !== exp_r.value) begin
            errors++;
            $display("%0t: value mismatch, expected %h, got %h", $time, exp_r.value, out_value);
          end
          if (out_status !== exp_r.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp_r.status, out_status);
          end
          if (out_depth !== exp_r.depth) begin
            errors++;
            $display("%0t: depth mismatch, expected %0d, got %0d", $time, exp_r.depth, out_depth);
          end
        end
      end
      // accepted word: predict now; its result comes on a later strobe
      if (start && !busy) begin
        rpn_execute(psa_pkg::mode_t'(in_mode), in_operand, in_index, exp_r);
        pending_results.push_back(exp_r);
      end
    end
  end

  // watchdog on the command channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word accepted for %0d cycles", $time, stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // operands lean on the corners; zero feeds the divide by zero case
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = MOST_NEG;
      1:       v = MOST_POS;
      2:       v = '0;
      3:       v = MINUS_ONE;
      4:       v = 32'd1;
      5, 6:    v = $urandom_range(0, 200) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // one command word; an optional idle burst comes first, start stays high
  // between back-to-back words
  task automatic send_word(input psa_pkg::mode_t op, input logic [31:0] opnd,
                           input logic [7:0] idx);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= op;
    in_operand <= opnd;
    in_index   <= idx;
    do @(posedge clk); while (busy);
    words_sent++;
    case (op)
      psa_pkg::MODE_PUSH: if (depth_guess < psa_pkg::STACK_DEPTH) depth_guess++;
      psa_pkg::MODE_POP:  if (depth_guess > 0) depth_guess--;
      psa_pkg::MODE_ADD, psa_pkg::MODE_SUB, psa_pkg::MODE_MUL, psa_pkg::MODE_DIV:
        if (depth_guess >= 2) depth_guess--;
      default: ;
    endcase
  endtask

  // drop start and wait for every outstanding result, once the checker has
  // recorded the last accepted word
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    depth_guess = rpn_depth;
  endtask

  function automatic logic [7:0] pick_index();
    int lim;
    lim = (depth_guess > 255) ? 255 : depth_guess;
    if ($urandom_range(0, 3) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, lim));
  endfunction

  // a well formed postfix expression with random terms and operators,
  // pushes and operators interleaved so partial results nest
  task automatic send_expression();
    int pushes_left;
    int open_terms;
    pushes_left = $urandom_range(2, 6);
    open_terms  = 0;
    while (pushes_left > 0 || open_terms > 1) begin
      if (pushes_left > 0 && (open_terms < 2 || $urandom_range(0, 1) == 0)) begin
        send_word(psa_pkg::MODE_PUSH, pick_operand(), pick_index());
        pushes_left--;
        open_terms++;
      end else begin
        send_word(psa_pkg::mode_t'($urandom_range(int'(psa_pkg::MODE_ADD),
                                                  int'(psa_pkg::MODE_DIV))),
                  pick_operand(), pick_index());
        open_terms--;
      end
    end
    case ($urandom_range(0, 3))
      0:       send_word(psa_pkg::MODE_POP, pick_operand(), pick_index());
      1:       send_word(psa_pkg::MODE_PEEK_TOP, pick_operand(), pick_index());
      2:       send_word(psa_pkg::MODE_PEEK_BOT, pick_operand(), pick_index());
      default: ;   // leave the result for later expressions
    endcase
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // empty, too few and range errors on an empty or nearly empty stack
  task automatic test_empty_stack_errors();
    send_word(psa_pkg::MODE_POP,      MOST_POS,  8'd0);
    send_word(psa_pkg::MODE_ADD,      '0,        8'd0);
    send_word(psa_pkg::MODE_PEEK_TOP, '0,        8'd0);
    send_word(psa_pkg::MODE_PEEK_BOT, '0,        8'd255);
    send_word(psa_pkg::MODE_PUSH,     MOST_NEG,  8'd255);
    send_word(psa_pkg::MODE_SUB,      '0,        8'd0);
    send_word(psa_pkg::MODE_DIV,      '0,        8'd0);
    send_word(psa_pkg::MODE_MUL,      '0,        8'd0);
    send_word(psa_pkg::MODE_PEEK_TOP, '0,        8'd0);
    send_word(psa_pkg::MODE_PEEK_BOT, '0,        8'd1);
  endtask

  // wraps, the most negative over minus one, divide by zero, truncation
  task automatic test_arith_corners();
    send_word(psa_pkg::MODE_PUSH, MOST_POS,      8'd0);
    send_word(psa_pkg::MODE_PUSH, 32'd1,         8'd0);
    send_word(psa_pkg::MODE_ADD,  '0,            8'd0);   // wraps to most negative
    send_word(psa_pkg::MODE_PUSH, MINUS_ONE,     8'd0);
    send_word(psa_pkg::MODE_DIV,  '0,            8'd0);   // most negative over minus one
    send_word(psa_pkg::MODE_PUSH, '0,            8'd0);
    send_word(psa_pkg::MODE_DIV,  '0,            8'd0);   // by zero, both operands gone
    send_word(psa_pkg::MODE_PUSH, -32'sd7,       8'd0);
    send_word(psa_pkg::MODE_PUSH, 32'd2,         8'd0);
    send_word(psa_pkg::MODE_DIV,  '0,            8'd0);   // truncates toward zero
    send_word(psa_pkg::MODE_PUSH, 32'h0001_0000, 8'd0);
    send_word(psa_pkg::MODE_PUSH, 32'h0001_0000, 8'd0);
    send_word(psa_pkg::MODE_MUL,  '0,            8'd0);   // product wraps to zero
    send_word(psa_pkg::MODE_SUB,  '0,            8'd0);
    send_word(psa_pkg::MODE_POP,  '0,            8'd0);
  endtask

  // fill to the top, refused pushes, peeks at the far ends, then unwind
  task automatic test_full_stack();
    drain();
    while (depth_guess < psa_pkg::STACK_DEPTH) begin
      send_word(psa_pkg::MODE_PUSH, pick_operand(), pick_index());
    end
    send_word(psa_pkg::MODE_PUSH,     MOST_POS,       8'd0);
    send_word(psa_pkg::MODE_PUSH,     MOST_NEG,       8'd0);
    send_word(psa_pkg::MODE_PEEK_TOP, '0,             8'd255);
    send_word(psa_pkg::MODE_PEEK_BOT, '0,             8'd255);
    send_word(psa_pkg::MODE_PEEK_BOT, '0,             8'd0);
    send_word(psa_pkg::MODE_PEEK_TOP, '0,             8'd0);
    send_word(psa_pkg::MODE_ADD,      '0,             8'd0);
    send_word(psa_pkg::MODE_PUSH,     pick_operand(), 8'd0);
    repeat (100) send_word(psa_pkg::MODE_POP, pick_operand(), pick_index());
    drain();
  endtask

  // random programs in chunks of about a hundred words; with idles allowed
  // most chunks idle in bursts and some run flat out
  task automatic test_random_programs(input int word_target, input bit idles_allowed);
    int chunk_end;
    while (words_sent < word_target) begin
      sender_idles = idles_allowed && ($urandom_range(0, 3) != 0);
      chunk_end    = words_sent + 100;
      while (words_sent < chunk_end && words_sent < word_target) begin
        if (depth_guess > 200) begin
          repeat ($urandom_range(20, 60)) begin
            send_word(psa_pkg::MODE_POP, pick_operand(), pick_index());
          end
        end else if ($urandom_range(0, 49) == 0) begin
          // run the stack dry and past it
          repeat (depth_guess + 2) send_word(psa_pkg::MODE_POP, pick_operand(), pick_index());
        end else if ($urandom_range(0, 9) < 7) begin
          send_expression();
        end else begin
          send_word(psa_pkg::mode_t'($urandom_range(0, 7)), pick_operand(), pick_index());
        end
      end
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idles = 1'b1;
    test_empty_stack_errors();
    test_arith_corners();
    test_full_stack();
    test_random_programs(WORDS_IDLING, 1'b1);
    // closing stretch with no sender gaps at all
    test_random_programs(WORDS_TOTAL, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t: %0d expected result words never arrived, expected 0 left, got %0d",
               $time, pending_results.size(), pending_results.size());
    end

    $display("run covered %0d command words and %0d result words, stack filled to the top once",
             words_sent, results_checked);
    $display("status counts: ok %0d, empty %0d, too few %0d, range %0d, div zero %0d, full %0d",
             status_seen[psa_pkg::ST_OK], status_seen[psa_pkg::ST_EMPTY],
             status_seen[psa_pkg::ST_FEW], status_seen[psa_pkg::ST_RANGE],
             status_seen[psa_pkg::ST_DIV0], status_seen[psa_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/psa_pkg.sv
sv/psa_div.sv
sv/psa_dpath.sv
sv/psa_ctrl.sv
sv/postfix_stack_alu.sv
verif/tb_postfix_stack_alu.sv
